[design/assert_macros.svh]
// Assertion helpers used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBRT_ASSERT_SAME(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (conseq)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBRT_ASSERT_NEXT(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (conseq)) \
        else $error(msg);

`endif

[design/sbrt_pkg.sv]
package sbrt_pkg;

    localparam int BYTE_W     = 8;
    localparam int THRESH_W   = 24;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 24'd392657;

    localparam int BIT_CNT_W  = 12;
    localparam int PAIR_CNT_W = 11;
    localparam int MIN_BITS   = 21;

    // Statistic format: signed, 16 fraction bits, 29 bits total.
    localparam int FRAC_BITS  = 16;
    localparam int STAT_W     = 29;
    localparam int QUOT_W     = STAT_W - 1;
    localparam int SAT_SHIFT  = QUOT_W - FRAC_BITS;
    localparam logic [STAT_W-1:0] STAT_MAX = {1'b0, {(STAT_W-1){1'b1}}};
    localparam logic [STAT_W-1:0] STAT_MIN = {1'b1, {(STAT_W-1){1'b0}}};

    typedef struct packed {
        logic load;
        logic clear;
    } cnt_ctrl_t;

    typedef struct packed {
        logic busy;
    } cnt_status_t;

    typedef struct packed {
        logic start;
    } stat_ctrl_t;

    typedef struct packed {
        logic done;
    } stat_status_t;

endpackage

[design/sbrt_counts.sv]
module sbrt_counts #(
    parameter int MAX_BYTES = 256,
    localparam int NW = $clog2(MAX_BYTES + 1) + 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sbrt_pkg::cnt_ctrl_t           ctrl,
    input  logic [sbrt_pkg::BYTE_W-1:0]   byte_in,
    output sbrt_pkg::cnt_status_t         status,
    output logic [NW-1:0]                 bit_count,
    output logic [NW-1:0]                 zero_count,
    output logic [NW-1:0]                 one_count,
    output logic [3:0][NW-1:0]            pair_count
);

    localparam int BCW = NW - 3;
    localparam int LW  = $clog2(sbrt_pkg::BYTE_W + 1);

    logic [BCW-1:0]                byte_cnt_reg, byte_cnt_next;
    logic [NW-1:0]                 zero_reg, zero_next;
    logic [NW-1:0]                 one_reg, one_next;
    logic [3:0][NW-1:0]            pair_reg, pair_next;
    logic                          prev_reg, prev_next;
    logic                          have_prev_reg, have_prev_next;
    logic [LW-1:0]                 left_reg, left_next;
    logic [sbrt_pkg::BYTE_W-1:0]   shift_reg, shift_next;
    logic                          cur_bit;
    logic [1:0]                    pair_idx;
    logic                          full;

    assign full     = (byte_cnt_reg == BCW'(MAX_BYTES));
    assign cur_bit  = shift_reg[sbrt_pkg::BYTE_W-1];
    assign pair_idx = {prev_reg, cur_bit};

    // One bit of the loaded word is taken per cycle, most significant first.
    always_comb begin
        byte_cnt_next  = byte_cnt_reg;
        zero_next      = zero_reg;
        one_next       = one_reg;
        pair_next      = pair_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        left_next      = left_reg;
        shift_next     = shift_reg;
        if (ctrl.clear) begin
            byte_cnt_next  = '0;
            zero_next      = '0;
            one_next       = '0;
            pair_next      = '0;
            prev_next      = 1'b0;
            have_prev_next = 1'b0;
            left_next      = '0;
        end else if (ctrl.load) begin
            if (!full) begin
                shift_next = byte_in;
                left_next  = LW'(sbrt_pkg::BYTE_W);
            end
        end else if (left_reg != '0) begin
            if (cur_bit) begin
                one_next = one_reg + NW'(1);
            end else begin
                zero_next = zero_reg + NW'(1);
            end
            // The very first bit of a sequence has no predecessor to pair with.
            if (have_prev_reg) begin
                pair_next[pair_idx] = pair_reg[pair_idx] + NW'(1);
            end
            prev_next      = cur_bit;
            have_prev_next = 1'b1;
            shift_next     = {shift_reg[sbrt_pkg::BYTE_W-2:0], 1'b0};
            left_next      = left_reg - LW'(1);
            if (left_reg == LW'(1)) begin
                byte_cnt_next = byte_cnt_reg + BCW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_cnt_reg  <= '0;
            zero_reg      <= '0;
            one_reg       <= '0;
            pair_reg      <= '0;
            prev_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            left_reg      <= '0;
        end else begin
            byte_cnt_reg  <= byte_cnt_next;
            zero_reg      <= zero_next;
            one_reg       <= one_next;
            pair_reg      <= pair_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

    assign status.busy = (left_reg != '0);
    assign bit_count   = {byte_cnt_reg, 3'b000};
    assign zero_count  = zero_reg;
    assign one_count   = one_reg;
    assign pair_count  = pair_reg;

endmodule

[design/sbrt_stat.sv]
module sbrt_stat #(
    parameter int NW = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sbrt_pkg::stat_ctrl_t              ctrl,
    input  logic [NW-1:0]                     bit_count,
    input  logic [NW-1:0]                     zero_count,
    input  logic [NW-1:0]                     one_count,
    input  logic [3:0][NW-1:0]                pair_count,
    output sbrt_pkg::stat_status_t            status,
    output logic [sbrt_pkg::STAT_W-1:0]       stat_value
);

    localparam int PW     = 3 * NW;
    localparam int AW     = 3 * NW + 4;
    localparam int DW     = 2 * NW;
    localparam int RW     = 2 * NW + 1;
    localparam int QW     = sbrt_pkg::QUOT_W;
    localparam int STEP_W = $clog2(QW);

    localparam logic [STEP_W-1:0] STEP_SQ00 = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_SQ01 = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_SQ10 = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_SQ11 = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_SQN0 = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_SQN1 = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_NS   = STEP_W'(6);
    localparam logic [STEP_W-1:0] STEP_NT   = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_NN   = STEP_W'(8);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QW - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_ABS  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } stat_state_t;

    stat_state_t                  state_reg, state_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic                         prep_reg, prep_next;
    logic                         done_reg, done_next;
    logic [PW-1:0]                prod_reg, prod_next;
    logic [DW-1:0]                s_reg, s_next;
    logic [DW-1:0]                t_reg, t_next;
    logic [DW-1:0]                den_reg, den_next;
    logic [AW-1:0]                acc_reg, acc_next;
    logic                         neg_reg, neg_next;
    logic                         sat_reg, sat_next;
    logic [RW-1:0]                rem_reg, rem_next;
    logic [QW-1:0]                quot_reg, quot_next;
    logic [sbrt_pkg::STAT_W-1:0]  stat_reg, stat_next;

    logic [NW-1:0]                op_a;
    logic [DW-1:0]                op_b;
    logic [AW-1:0]                acc_hi;
    logic [RW-1:0]                rem_shift;
    logic [RW:0]                  rem_diff;

    // Operand selection for the one shared multiplier.
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            STEP_SQ00: begin
                op_a = pair_count[0];
                op_b = DW'(pair_count[0]);
            end
            STEP_SQ01: begin
                op_a = pair_count[1];
                op_b = DW'(pair_count[1]);
            end
            STEP_SQ10: begin
                op_a = pair_count[2];
                op_b = DW'(pair_count[2]);
            end
            STEP_SQ11: begin
                op_a = pair_count[3];
                op_b = DW'(pair_count[3]);
            end
            STEP_SQN0: begin
                op_a = zero_count;
                op_b = DW'(zero_count);
            end
            STEP_SQN1: begin
                op_a = one_count;
                op_b = DW'(one_count);
            end
            STEP_NS: begin
                op_a = bit_count;
                op_b = s_reg;
            end
            STEP_NT: begin
                op_a = bit_count - NW'(1);
                op_b = t_reg;
            end
            STEP_NN: begin
                op_a = bit_count;
                op_b = DW'(bit_count - NW'(1));
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign acc_hi    = acc_reg >> sbrt_pkg::SAT_SHIFT;
    assign rem_shift = {rem_reg[RW-2:0], quot_reg[QW-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, den_reg};

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        prep_next  = prep_reg;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        s_next     = s_reg;
        t_next     = t_reg;
        den_next   = den_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        stat_next  = stat_reg;
        case (state_reg)
            ST_IDLE: begin
                if (ctrl.start) begin
                    step_next  = STEP_SQ00;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = PW'(op_a) * PW'(op_b);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                // num = 4*n*S - 2*(n-1)*T + n*(n-1), den = n*(n-1)
                case (step_reg)
                    STEP_SQ00: s_next = DW'(prod_reg);
                    STEP_SQ01: s_next = s_reg + DW'(prod_reg);
                    STEP_SQ10: s_next = s_reg + DW'(prod_reg);
                    STEP_SQ11: s_next = s_reg + DW'(prod_reg);
                    STEP_SQN0: t_next = DW'(prod_reg);
                    STEP_SQN1: t_next = t_reg + DW'(prod_reg);
                    STEP_NS:   acc_next = AW'(prod_reg) << 2;
                    STEP_NT:   acc_next = acc_reg - (AW'(prod_reg) << 1);
                    STEP_NN: begin
                        acc_next = acc_reg + AW'(prod_reg);
                        den_next = DW'(prod_reg);
                    end
                    default: acc_next = acc_reg;
                endcase
                if (step_reg == STEP_NN) begin
                    prep_next  = 1'b0;
                    state_next = ST_ABS;
                end else begin
                    step_next  = step_reg + STEP_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_ABS: begin
                // With prep_reg clear it takes the magnitude; with it set, it checks for saturation
                // and loads the divider.
                if (!prep_reg) begin
                    neg_next  = acc_reg[AW-1];
                    acc_next  = acc_reg[AW-1] ? ('0 - acc_reg) : acc_reg;
                    prep_next = 1'b1;
                end else begin
                    sat_next   = (acc_hi >= AW'(den_reg));
                    rem_next   = RW'(acc_hi);
                    quot_next  = {acc_reg[sbrt_pkg::SAT_SHIFT-1:0],
                                  {sbrt_pkg::FRAC_BITS{1'b0}}};
                    step_next  = '0;
                    state_next = (acc_hi >= AW'(den_reg)) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (!rem_diff[RW]) begin
                    rem_next  = rem_diff[RW-1:0];
                    quot_next = {quot_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next  = rem_shift;
                    quot_next = {quot_reg[QW-2:0], 1'b0};
                end
                if (step_reg == STEP_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DONE: begin
                // Negative values round toward minus infinity.
                if (sat_reg) begin
                    stat_next = neg_reg ? sbrt_pkg::STAT_MIN : sbrt_pkg::STAT_MAX;
                end else if (neg_reg) begin
                    stat_next = '0 - (sbrt_pkg::STAT_W'(quot_reg)
                                      + sbrt_pkg::STAT_W'(rem_reg != '0));
                end else begin
                    stat_next = sbrt_pkg::STAT_W'(quot_reg);
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            prep_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            prep_reg  <= prep_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        s_reg    <= s_next;
        t_reg    <= t_next;
        den_reg  <= den_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        stat_reg <= stat_next;
    end

    assign status.done = done_reg;
    assign stat_value  = stat_reg;

endmodule

[design/serial_two_bit_randomness_test.sv]
// Channel   Direction  Payload                                      Handshake
// s_        in         byte_value, last_byte                        s_valid / s_ready
// m_        out        counts, statistic, passed, insufficient      m_valid / m_ready
// cfg_      in         pass_threshold                               cfg_wr_en, no wait
//
// A counted word is accepted, then its eight bits shift through the counters one
// per cycle, then the block returns to idle. A word past MAX_BYTES is not counted.
// A last word with enough bits adds the statistic: nine multiplies on the shared
// multiplier, each a multiply and an accumulate state, then a restoring divider.
// Reset clears all counters and sets the threshold to 5.9915; a result held
// on a stalled m_ channel only blocks the next last word, not the counting.
module serial_two_bit_randomness_test #(
    parameter int MAX_BYTES = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [sbrt_pkg::THRESH_W-1:0]        cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [sbrt_pkg::BYTE_W-1:0]          s_byte_value,
    input  logic                                 s_last_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [sbrt_pkg::BIT_CNT_W-1:0]       m_bit_count,
    output logic [sbrt_pkg::BIT_CNT_W-1:0]       m_zero_bits,
    output logic [sbrt_pkg::BIT_CNT_W-1:0]       m_one_bits,
    output logic [sbrt_pkg::PAIR_CNT_W-1:0]      m_pairs_00,
    output logic [sbrt_pkg::PAIR_CNT_W-1:0]      m_pairs_01,
    output logic [sbrt_pkg::PAIR_CNT_W-1:0]      m_pairs_10,
    output logic [sbrt_pkg::PAIR_CNT_W-1:0]      m_pairs_11,
    output logic signed [sbrt_pkg::STAT_W-1:0]   m_statistic,
    output logic                                 m_passed,
    output logic                                 m_insufficient
);

    localparam int NW = $clog2(MAX_BYTES + 1) + 3;
    localparam int XW = (NW > sbrt_pkg::BIT_CNT_W) ? NW : sbrt_pkg::BIT_CNT_W;
    localparam int CW = sbrt_pkg::BIT_CNT_W;
    localparam int PCW = sbrt_pkg::PAIR_CNT_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_BITS = 5'b00010,
        S_EVAL = 5'b00100,
        S_STAT = 5'b01000,
        S_PUT  = 5'b10000
    } top_state_t;

    top_state_t                     state_reg, state_next;
    logic                           last_reg, last_next;
    logic                           insuff_reg, insuff_next;
    logic [sbrt_pkg::THRESH_W-1:0]  thresh_reg;
    logic                           m_valid_reg, m_valid_next;
    logic                           load_out;

    logic [CW-1:0]                  bit_count_reg, zero_bits_reg, one_bits_reg;
    logic [PCW-1:0]                 p00_reg, p01_reg, p10_reg, p11_reg;
    logic [sbrt_pkg::STAT_W-1:0]    stat_reg;
    logic                           passed_reg;
    logic                           insuff_out_reg;

    sbrt_pkg::cnt_ctrl_t            cnt_ctrl;
    sbrt_pkg::cnt_status_t          cnt_status;
    sbrt_pkg::stat_ctrl_t           stat_ctrl;
    sbrt_pkg::stat_status_t         stat_status;

    logic [NW-1:0]                  bit_count;
    logic [NW-1:0]                  zero_count;
    logic [NW-1:0]                  one_count;
    logic [3:0][NW-1:0]             pair_count;
    logic [sbrt_pkg::STAT_W-1:0]    stat_value;

    logic [XW-1:0]                  n_ext, n0_ext, n1_ext;
    logic [XW-1:0]                  p00_ext, p01_ext, p10_ext, p11_ext;
    logic [sbrt_pkg::STAT_W-1:0]    stat_out;
    logic                           passed_out;

    sbrt_counts #(
        .MAX_BYTES (MAX_BYTES)
    ) u_counts (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (cnt_ctrl),
        .byte_in    (s_byte_value),
        .status     (cnt_status),
        .bit_count  (bit_count),
        .zero_count (zero_count),
        .one_count  (one_count),
        .pair_count (pair_count)
    );

    sbrt_stat #(
        .NW (NW)
    ) u_stat (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (stat_ctrl),
        .bit_count  (bit_count),
        .zero_count (zero_count),
        .one_count  (one_count),
        .pair_count (pair_count),
        .status     (stat_status),
        .stat_value (stat_value)
    );

    always_comb begin
        state_next      = state_reg;
        last_next       = last_reg;
        insuff_next     = insuff_reg;
        cnt_ctrl.load   = 1'b0;
        cnt_ctrl.clear  = 1'b0;
        stat_ctrl.start = 1'b0;
        load_out        = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cnt_ctrl.load = 1'b1;
                    last_next     = s_last_byte;
                    state_next    = S_BITS;
                end
            end
            S_BITS: begin
                if (!cnt_status.busy) begin
                    state_next = last_reg ? S_EVAL : S_IDLE;
                end
            end
            S_EVAL: begin
                insuff_next = (bit_count < NW'(sbrt_pkg::MIN_BITS));
                if (bit_count < NW'(sbrt_pkg::MIN_BITS)) begin
                    state_next = S_PUT;
                end else begin
                    stat_ctrl.start = 1'b1;
                    state_next      = S_STAT;
                end
            end
            S_STAT: begin
                if (stat_status.done) begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                // Wait until the output register is free, then clear the counters.
                if (!m_valid_reg || m_ready) begin
                    load_out       = 1'b1;
                    m_valid_next   = 1'b1;
                    cnt_ctrl.clear = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign n_ext   = XW'(bit_count);
    assign n0_ext  = XW'(zero_count);
    assign n1_ext  = XW'(one_count);
    assign p00_ext = XW'(pair_count[0]);
    assign p01_ext = XW'(pair_count[1]);
    assign p10_ext = XW'(pair_count[2]);
    assign p11_ext = XW'(pair_count[3]);

    assign stat_out   = insuff_reg ? '0 : stat_value;
    assign passed_out = !insuff_reg && ($signed(stat_value) <= $signed(
        {{(sbrt_pkg::STAT_W - sbrt_pkg::THRESH_W){1'b0}}, thresh_reg}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            last_reg    <= 1'b0;
            insuff_reg  <= 1'b0;
            thresh_reg  <= sbrt_pkg::THRESH_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            last_reg    <= last_next;
            insuff_reg  <= insuff_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                thresh_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            bit_count_reg  <= n_ext[CW-1:0];
            zero_bits_reg  <= n0_ext[CW-1:0];
            one_bits_reg   <= n1_ext[CW-1:0];
            p00_reg        <= p00_ext[PCW-1:0];
            p01_reg        <= p01_ext[PCW-1:0];
            p10_reg        <= p10_ext[PCW-1:0];
            p11_reg        <= p11_ext[PCW-1:0];
            stat_reg       <= stat_out;
            passed_reg     <= passed_out;
            insuff_out_reg <= insuff_reg;
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_bit_count    = bit_count_reg;
    assign m_zero_bits    = zero_bits_reg;
    assign m_one_bits     = one_bits_reg;
    assign m_pairs_00     = p00_reg;
    assign m_pairs_01     = p01_reg;
    assign m_pairs_10     = p10_reg;
    assign m_pairs_11     = p11_reg;
    assign m_statistic    = $signed(stat_reg);
    assign m_passed       = passed_reg;
    assign m_insufficient = insuff_out_reg;

endmodule

[design/sbrt_checker.sv]
`include "assert_macros.svh"

module sbrt_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [sbrt_pkg::BIT_CNT_W-1:0]       m_bit_count,
    input logic [sbrt_pkg::BIT_CNT_W-1:0]       m_zero_bits,
    input logic [sbrt_pkg::BIT_CNT_W-1:0]       m_one_bits,
    input logic [sbrt_pkg::PAIR_CNT_W-1:0]      m_pairs_00,
    input logic [sbrt_pkg::PAIR_CNT_W-1:0]      m_pairs_01,
    input logic [sbrt_pkg::PAIR_CNT_W-1:0]      m_pairs_10,
    input logic [sbrt_pkg::PAIR_CNT_W-1:0]      m_pairs_11,
    input logic signed [sbrt_pkg::STAT_W-1:0]   m_statistic,
    input logic                                 m_passed,
    input logic                                 m_insufficient
);

    // A stalled result word must stay in place.
    `SBRT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_statistic) && $stable(m_bit_count), "result word changed while stalled")

    // Too short a sequence reports no statistic and never passes.
    `SBRT_ASSERT_SAME(a_insuff_zero, aclk, aresetn, m_valid && m_insufficient, m_statistic == '0 && !m_passed, "insufficient result carries a statistic")

    // Every counted bit is either a zero or a one.
    `SBRT_ASSERT_SAME(a_bit_split, aclk, aresetn, m_valid, 12'(m_zero_bits + m_one_bits) == m_bit_count, "zero and one counts do not add up")

    // Overlapping pairs number one less than the bits.
    `SBRT_ASSERT_SAME(a_pair_total, aclk, aresetn, m_valid && !m_insufficient, 11'(m_pairs_00 + m_pairs_01 + m_pairs_10 + m_pairs_11) == 11'(m_bit_count - 12'd1), "pair counts do not match bit count")

    // A negative statistic is always below the unsigned threshold.
    `SBRT_ASSERT_SAME(a_neg_pass, aclk, aresetn, m_valid && m_statistic[sbrt_pkg::STAT_W-1], m_passed, "negative statistic did not pass")

endmodule

bind serial_two_bit_randomness_test sbrt_checker u_sbrt_checker (.*);

[dv/serial_two_bit_randomness_test_tb.sv]
`timescale 1ns / 100ps

module serial_two_bit_randomness_test_tb;

    localparam int     MAX_BYTES   = 256;
    localparam int     SETTLE      = 80;
    localparam int     HOLD_LEN    = 600;
    localparam int     PHASE_WORDS = 24;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint STAT_HI     = (longint'(1) <<< (sbrt_pkg::STAT_W - 1)) - 1;
    localparam longint STAT_LO     = -(longint'(1) <<< (sbrt_pkg::STAT_W - 1));

    typedef struct packed {
        logic [sbrt_pkg::BIT_CNT_W-1:0]  bit_count;
        logic [sbrt_pkg::BIT_CNT_W-1:0]  zero_bits;
        logic [sbrt_pkg::BIT_CNT_W-1:0]  one_bits;
        logic [sbrt_pkg::PAIR_CNT_W-1:0] pairs_00;
        logic [sbrt_pkg::PAIR_CNT_W-1:0] pairs_01;
        logic [sbrt_pkg::PAIR_CNT_W-1:0] pairs_10;
        logic [sbrt_pkg::PAIR_CNT_W-1:0] pairs_11;
        logic [sbrt_pkg::STAT_W-1:0]     statistic;
        logic                            passed;
        logic                            insufficient;
    } report_t;

    typedef struct packed {
        logic [sbrt_pkg::BYTE_W-1:0] value;
        logic                        last;
        logic                        typed;
        report_t                     want;
    } script_row_t;

    typedef enum {FILL_RANDOM, FILL_REPEAT, FILL_SPARSE} fill_t;

    localparam report_t NO_REPORT = '0;

    // Rows marked typed carry their report written out; the rest go through the tally.
    localparam script_row_t SCRIPT [22] = '{
        '{8'h00, 1'b1, 1'b1,
          '{12'd8, 12'd8, 12'd0, 11'd7, 11'd0, 11'd0, 11'd0, 29'd0, 1'b0, 1'b1}},
        '{8'hFF, 1'b1, 1'b1,
          '{12'd8, 12'd0, 12'd8, 11'd0, 11'd0, 11'd0, 11'd7, 29'd0, 1'b0, 1'b1}},
        '{8'hAA, 1'b0, 1'b0, NO_REPORT},
        '{8'h55, 1'b1, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b1, 1'b1,
          '{12'd24, 12'd24, 12'd0, 11'd23, 11'd0, 11'd0, 11'd0, 29'd2949120, 1'b0, 1'b0}},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b1, 1'b1,
          '{12'd24, 12'd0, 12'd24, 11'd0, 11'd0, 11'd0, 11'd23, 29'd2949120, 1'b0, 1'b0}},
        '{8'h0F, 1'b0, 1'b0, NO_REPORT},
        '{8'hF0, 1'b0, 1'b0, NO_REPORT},
        '{8'h3C, 1'b1, 1'b0, NO_REPORT},
        '{8'hAA, 1'b0, 1'b0, NO_REPORT},
        '{8'hAA, 1'b0, 1'b0, NO_REPORT},
        '{8'hAA, 1'b1, 1'b0, NO_REPORT},
        '{8'h5A, 1'b0, 1'b0, NO_REPORT},
        '{8'hC3, 1'b0, 1'b0, NO_REPORT},
        '{8'h96, 1'b0, 1'b0, NO_REPORT},
        '{8'h71, 1'b1, 1'b0, NO_REPORT},
        '{8'h80, 1'b0, 1'b0, NO_REPORT},
        '{8'h01, 1'b1, 1'b0, NO_REPORT}
    };

    logic                                  aclk = 1'b0;
    logic                                  aresetn;
    logic                                  cfg_wr_en;
    logic [sbrt_pkg::THRESH_W-1:0]         cfg_wr_data;
    logic                                  s_valid;
    logic                                  s_ready;
    logic [sbrt_pkg::BYTE_W-1:0]           s_byte_value;
    logic                                  s_last_byte;
    logic                                  m_valid;
    logic                                  m_ready = 1'b0;
    logic [sbrt_pkg::BIT_CNT_W-1:0]        m_bit_count;
    logic [sbrt_pkg::BIT_CNT_W-1:0]        m_zero_bits;
    logic [sbrt_pkg::BIT_CNT_W-1:0]        m_one_bits;
    logic [sbrt_pkg::PAIR_CNT_W-1:0]       m_pairs_00;
    logic [sbrt_pkg::PAIR_CNT_W-1:0]       m_pairs_01;
    logic [sbrt_pkg::PAIR_CNT_W-1:0]       m_pairs_10;
    logic [sbrt_pkg::PAIR_CNT_W-1:0]       m_pairs_11;
    logic signed [sbrt_pkg::STAT_W-1:0]    m_statistic;
    logic                                  m_passed;
    logic                                  m_insufficient;

    // Running tally of the sequence in flight, mirrored from the block.
    logic [8:0]                            words_taken;
    logic [sbrt_pkg::BIT_CNT_W-1:0]        zeros_seen;
    logic [sbrt_pkg::BIT_CNT_W-1:0]        ones_seen;
    logic [sbrt_pkg::PAIR_CNT_W-1:0]       pairs_seen [4];
    logic                                  prior_bit;
    logic [sbrt_pkg::THRESH_W-1:0]         limit_q16;
    report_t                               pending_reports [$];

    int                                    tx_idle_pct = 0;
    int                                    rx_stall_pct = 0;
    int                                    mismatches = 0;
    longint                                cycles = 0;
    logic                                  hold_flip = 1'b0;
    logic                                  hold_seen = 1'b0;
    int                                    hold_left = 0;

    serial_two_bit_randomness_test #(
        .MAX_BYTES(MAX_BYTES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_value  (s_byte_value),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bit_count   (m_bit_count),
        .m_zero_bits   (m_zero_bits),
        .m_one_bits    (m_one_bits),
        .m_pairs_00    (m_pairs_00),
        .m_pairs_01    (m_pairs_01),
        .m_pairs_10    (m_pairs_10),
        .m_pairs_11    (m_pairs_11),
        .m_statistic   (m_statistic),
        .m_passed      (m_passed),
        .m_insufficient(m_insufficient)
    );

    always #5 aclk = ~aclk;

    task automatic clear_tally();
        words_taken = '0;
        zeros_seen = '0;
        ones_seen = '0;
        for (int k = 0; k < 4; k++) pairs_seen[k] = '0;
        prior_bit = 1'b0;
    endtask

    // Folds a word in below MAX_BYTES; a last word closes the sequence and queues its report.
    task automatic tally_word(input logic [sbrt_pkg::BYTE_W-1:0] value, input logic last);
        report_t rep;
        longint  n, p, z, o, sq_pairs, sq_bits, num, den, q, thr;
        logic    cur;
        if (int'(words_taken) < MAX_BYTES) begin
            for (int k = sbrt_pkg::BYTE_W - 1; k >= 0; k--) begin
                cur = value[k];
                if (cur) ones_seen++;
                else zeros_seen++;
                if (words_taken != '0 || k != sbrt_pkg::BYTE_W - 1) begin
                    pairs_seen[{prior_bit, cur}]++;
                end
                prior_bit = cur;
            end
            words_taken++;
        end
        if (!last) return;

        n = longint'(words_taken);
        n = n * sbrt_pkg::BYTE_W;
        z = longint'(zeros_seen);
        o = longint'(ones_seen);
        rep = '0;
        rep.bit_count = n[sbrt_pkg::BIT_CNT_W-1:0];
        rep.zero_bits = zeros_seen;
        rep.one_bits = ones_seen;
        rep.pairs_00 = pairs_seen[0];
        rep.pairs_01 = pairs_seen[1];
        rep.pairs_10 = pairs_seen[2];
        rep.pairs_11 = pairs_seen[3];
        rep.insufficient = n < sbrt_pkg::MIN_BITS;
        if (!rep.insufficient) begin
            sq_pairs = 0;
            for (int k = 0; k < 4; k++) begin
                p = longint'(pairs_seen[k]);
                sq_pairs += p * p;
            end
            sq_bits = z * z + o * o;
            // Scale the whole rational up front, then divide once and round down.
            num = (4 * n * sq_pairs - 2 * (n - 1) * sq_bits + n * (n - 1))
                  <<< sbrt_pkg::FRAC_BITS;
            den = n * (n - 1);
            q = num / den;
            if (num % den != 0 && num < 0) q--;
            if (q > STAT_HI) q = STAT_HI;
            if (q < STAT_LO) q = STAT_LO;
            thr = longint'(limit_q16);
            rep.statistic = q[sbrt_pkg::STAT_W-1:0];
            rep.passed = q <= thr;
        end
        pending_reports.push_back(rep);
        clear_tally();
    endtask

    task automatic send_word(input logic [sbrt_pkg::BYTE_W-1:0] value, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_value <= value;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tally_word(value, last);
    endtask

    // A word that closes no sequence can still be in the counters, hence the settle time.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic load_threshold(input logic [sbrt_pkg::THRESH_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_q16 = value;
    endtask

    task automatic run_phase(input int tx_idle, input int rx_stall,
                             input logic [sbrt_pkg::THRESH_W-1:0] thr);
        int                          sent;
        int                          len;
        fill_t                       fill;
        logic [sbrt_pkg::BYTE_W-1:0] motif;
        logic [sbrt_pkg::BYTE_W-1:0] value;
        wait_drained();
        load_threshold(thr);
        tx_idle_pct = tx_idle;
        rx_stall_pct = rx_stall;
        sent = 0;
        while (sent < PHASE_WORDS) begin
            len = ($urandom_range(9) == 0) ? int'($urandom_range(60, 20))
                                           : int'($urandom_range(8, 1));
            if (len > PHASE_WORDS - sent) len = PHASE_WORDS - sent;
            fill = ($urandom_range(1) == 0) ? FILL_RANDOM : fill_t'($urandom_range(2));
            motif = sbrt_pkg::BYTE_W'($urandom);
            for (int i = 0; i < len; i++) begin
                case (fill)
                    FILL_REPEAT: value = motif;
                    FILL_SPARSE: value = sbrt_pkg::BYTE_W'($urandom & $urandom & $urandom);
                    default: value = sbrt_pkg::BYTE_W'($urandom);
                endcase
                send_word(value, i == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("report with no sequence closed: bit_count %0d", m_bit_count);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("bit_count", longint'(want.bit_count), longint'(m_bit_count));
                check_field("zero_bits", longint'(want.zero_bits), longint'(m_zero_bits));
                check_field("one_bits", longint'(want.one_bits), longint'(m_one_bits));
                check_field("pairs_00", longint'(want.pairs_00), longint'(m_pairs_00));
                check_field("pairs_01", longint'(want.pairs_01), longint'(m_pairs_01));
                check_field("pairs_10", longint'(want.pairs_10), longint'(m_pairs_10));
                check_field("pairs_11", longint'(want.pairs_11), longint'(m_pairs_11));
                check_field("statistic", longint'($signed(want.statistic)),
                            longint'(m_statistic));
                check_field("passed", longint'(want.passed), longint'(m_passed));
                check_field("insufficient", longint'(want.insufficient),
                            longint'(m_insufficient));
            end
        end
    end

    // The receiver runs a long hold-off each time the main flow flips hold_flip.
    always @(posedge aclk) begin
        if (hold_flip != hold_seen) begin
            hold_seen <= hold_flip;
            hold_left <= HOLD_LEN;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_byte_value = '0;
        s_last_byte = 1'b0;
        clear_tally();
        limit_q16 = sbrt_pkg::THRESH_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < $size(SCRIPT); i++) begin
            send_word(SCRIPT[i].value, SCRIPT[i].last);
            if (SCRIPT[i].typed) pending_reports[pending_reports.size() - 1] = SCRIPT[i].want;
        end

        // Run past the byte limit; the closing word itself is ignored but still reports.
        for (int i = 0; i < MAX_BYTES + 2; i++) send_word(8'h00, i == MAX_BYTES + 1);

        // Hold the result channel so queued reports back up into the input.
        wait_drained();
        hold_flip <= ~hold_flip;
        for (int i = 0; i < 24; i++) send_word(sbrt_pkg::BYTE_W'($urandom), i % 3 == 2);

        run_phase(0, 0, '0);
        run_phase(49, 0, '1);
        run_phase(0, 49, sbrt_pkg::THRESH_W'($urandom));
        run_phase(16, 16, 24'd393216);

        wait_drained();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/sbrt_pkg.sv
design/sbrt_counts.sv
design/sbrt_stat.sv
design/serial_two_bit_randomness_test.sv
design/sbrt_checker.sv
dv/serial_two_bit_randomness_test_tb.sv
